[rtl/key_stack_search_remove_core_macros.svh]
// Assertion macros shared by the checker of the key stack.
// They expect signals named clk_i and rst_ni where they are used.
`ifndef KEY_STACK_SEARCH_REMOVE_CORE_MACROS_SVH
`define KEY_STACK_SEARCH_REMOVE_CORE_MACROS_SVH

// A property checked at each rising edge, switched off while reset is held.
`define KSSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A property checked at each rising edge, reset included.
`define KSSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/kssr_pkg.sv]
// Package of the key stack: sizes, operation and status codes, word types.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package kssr_pkg;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned FILL_W    = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(DEPTH);

  typedef enum logic [2:0] {
    OpPush   = 3'd0,
    OpPop    = 3'd1,
    OpPeek   = 3'd2,
    OpCount  = 3'd3,
    OpSearch = 3'd4,
    OpRemove = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]           operation;
    logic [KEY_WIDTH-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [KEY_WIDTH-1:0] key_out;
    logic                 found;
    logic [3:0]           fill_count;
  } out_word_t;

  // Controls that the top level hands to every cell.
  typedef struct packed {
    logic valid;   // the cell holds a written entry
    logic load;    // take the pushed key
    logic remove;  // a remove with a match is under way
  } cell_ctrl_t;

endpackage

[rtl/kssr_cell.sv]
// One place of the key stack: the stored key, its compare and its shift.
// Depends on kssr_pkg.
`timescale 1ns / 1ps

module kssr_cell (
  input  logic                           clk_i,
  input  kssr_pkg::cell_ctrl_t           ctrl_i,
  input  logic [kssr_pkg::KEY_WIDTH-1:0] key_i,
  input  logic [kssr_pkg::KEY_WIDTH-1:0] above_entry_i,
  input  logic                           hit_above_i,
  output logic [kssr_pkg::KEY_WIDTH-1:0] entry_o,
  output logic                           hit_o
);
  import kssr_pkg::*;

  logic [KEY_WIDTH-1:0] entry_q, entry_d;
  logic                 shift;

  // The topmost match lies at or below this place when nothing above matched,
  // so this entry takes the one above it.
  assign shift = ctrl_i.remove && !hit_above_i;
  assign hit_o = hit_above_i || (ctrl_i.valid && (entry_q == key_i));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = key_i;
    end else if (shift) begin
      entry_d = above_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/key_stack_search_remove_core.sv]
// Key stack with search and remove: top level, a row of stack cells,
// the fill level and the output register. Depends on kssr_pkg and kssr_cell.
`timescale 1ns / 1ps

// Usage
// The block holds up to DEPTH keys as a last-in first-out stack. Each input
// word carries one operation (push, pop, peek, count, search, remove) and a
// key, and gives exactly one output word with status, key_out, found and the
// fill count after the operation.
// Both channels use valid and stall: a word moves at a rising edge where
// valid is high and stall is low.
// Every operation completes in the cycle of its acceptance; the output word
// is registered and shows in the cycle after the input word was taken. One
// word is accepted per cycle when not stalled, since each cell compares its
// own key and takes the entry from the cell above in the same cycle, and the
// topmost match is found by a hit signal that runs down the row of cells.
// When the receiver stalls, the held output word stays unchanged and the
// input is stalled only while that word waits, so the next word is accepted
// in the very cycle the pending one leaves.
// Reset empties the stack and drops any pending output word; the stored keys
// themselves are not cleared, as only entries below the fill level are read.
module key_stack_search_remove_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kssr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kssr_pkg::out_word_t out_word_o
);
  import kssr_pkg::*;

  logic [FILL_W-1:0]    fill_q, fill_d;
  logic                 out_valid_q;
  out_word_t            out_word_q;
  out_word_t            result;
  logic                 accept;
  logic                 is_empty, is_full;
  logic                 push_ok, remove_ok;
  logic [KEY_WIDTH-1:0] entries [DEPTH];
  logic [KEY_WIDTH-1:0] above [DEPTH];
  logic                 hit_in [DEPTH];
  logic                 hit_out [DEPTH];
  cell_ctrl_t           ctrl [DEPTH];
  logic [FILL_W-1:0]    top_pos;
  logic [KEY_WIDTH-1:0] top_key;
  logic                 any_hit;

  // The input waits only while a finished word is held back by the receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_empty = (fill_q == '0);
  assign is_full  = (fill_q == FILL_W'(DEPTH));
  assign top_pos  = fill_q - FILL_W'(1);
  assign top_key  = entries[top_pos[IDX_W-1:0]];
  assign any_hit  = hit_out[0];

  // Row of cells; the hit signal enters at the top and runs downwards.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign above[i]  = '0;
      assign hit_in[i] = 1'b0;
    end else begin : g_mid
      assign above[i]  = entries[i+1];
      assign hit_in[i] = hit_out[i+1];
    end

    assign ctrl[i].valid  = (FILL_W'(i) < fill_q);
    assign ctrl[i].load   = push_ok && (fill_q == FILL_W'(i));
    assign ctrl[i].remove = remove_ok;

    kssr_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .key_i        (in_word_i.key),
      .above_entry_i(above[i]),
      .hit_above_i  (hit_in[i]),
      .entry_o      (entries[i]),
      .hit_o        (hit_out[i])
    );
  end

  // Operation decode: status, result fields and the next fill level.
  always_comb begin
    fill_d         = fill_q;
    push_ok        = 1'b0;
    remove_ok      = 1'b0;
    result.status  = StOk;
    result.key_out = '0;
    result.found   = 1'b0;
    unique case (in_word_i.operation)
      OpPush: begin
        if (is_full) begin
          result.status = StFull;
        end else begin
          push_ok = accept;
          fill_d  = fill_q + FILL_W'(1);
        end
      end
      OpPop: begin
        if (is_empty) begin
          result.status = StEmpty;
        end else begin
          result.key_out = top_key;
          fill_d         = top_pos;
        end
      end
      OpPeek: begin
        if (is_empty) begin
          result.status = StEmpty;
        end else begin
          result.key_out = top_key;
        end
      end
      OpSearch: begin
        result.found = any_hit;
      end
      OpRemove: begin
        if (is_empty) begin
          result.status = StEmpty;
        end else if (!any_hit) begin
          result.status = StNotFound;
        end else begin
          remove_ok = accept;
          fill_d    = top_pos;
        end
      end
      default: begin
        // Count and the unused codes leave the stack as it is.
      end
    endcase
    result.fill_count = 4'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/kssr_checker.sv]
// Port-level checks of the key stack, bound to the top level.
// Depends on kssr_pkg and key_stack_search_remove_core_macros.svh.
`timescale 1ns / 1ps
`include "key_stack_search_remove_core_macros.svh"

module kssr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kssr_pkg::out_word_t out_word_o
);
  import kssr_pkg::*;

  logic in_take;
  logic out_wait;
  logic out_hit;
  logic out_full;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign out_hit  = out_valid_o && out_word_o.found;
  assign out_full = out_valid_o && (out_word_o.status == StFull);

  // A stalled output word stays offered and unchanged.
  `KSSR_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_word_o), "held word changed")

  // Every accepted word yields an output word in the next cycle.
  `KSSR_ASSERT(a_latency, in_take |=> out_valid_o, "no output word after an accepted input word")

  // A search hit is always reported with status ok.
  `KSSR_ASSERT(a_found_ok, out_hit |-> out_word_o.status == StOk, "found without status ok")

  // Full is reported only with the stack at its depth.
  `KSSR_ASSERT(a_full_depth, out_full |-> out_word_o.fill_count == 4'(DEPTH), "full below depth")

  // The input is never stalled while no output word is pending.
  `KSSR_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_wait, "stall with no word waiting")

endmodule

bind key_stack_search_remove_core kssr_checker u_kssr_checker (.*);
